@@ src/rv32i_instruction_encoder_defines.svh @@
// Assertion macros used by the encoder checker file.
`ifndef RV32I_INSTRUCTION_ENCODER_DEFINES_SVH
`define RV32I_INSTRUCTION_ENCODER_DEFINES_SVH

// Assert a property that is ignored while reset is high.
`define RIE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Assert a property that is checked during reset too.
`define RIE_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

@@ src/rv32ie_pkg.sv @@
// Types, constants and lookup tables of the RV32I instruction encoder.
package rv32ie_pkg;

   typedef logic [5:0]  cmd_type;
   typedef logic [4:0]  reg_type;
   typedef logic [31:0] word_type;
   typedef logic [2:0]  lay_type;

   localparam cmd_type OP_LUI     = 6'd0;
   localparam cmd_type OP_AUIPC   = 6'd1;
   localparam cmd_type OP_JAL     = 6'd2;
   localparam cmd_type OP_JALR    = 6'd3;
   localparam cmd_type OP_BEQ     = 6'd4;
   localparam cmd_type OP_BNE     = 6'd5;
   localparam cmd_type OP_BLT     = 6'd6;
   localparam cmd_type OP_BGE     = 6'd7;
   localparam cmd_type OP_BLTU    = 6'd8;
   localparam cmd_type OP_BGEU    = 6'd9;
   localparam cmd_type OP_LB      = 6'd10;
   localparam cmd_type OP_LH      = 6'd11;
   localparam cmd_type OP_LW      = 6'd12;
   localparam cmd_type OP_LBU     = 6'd13;
   localparam cmd_type OP_LHU     = 6'd14;
   localparam cmd_type OP_SB      = 6'd15;
   localparam cmd_type OP_SH      = 6'd16;
   localparam cmd_type OP_SW      = 6'd17;
   localparam cmd_type OP_ADDI    = 6'd18;
   localparam cmd_type OP_SLTI    = 6'd19;
   localparam cmd_type OP_SLTIU   = 6'd20;
   localparam cmd_type OP_XORI    = 6'd21;
   localparam cmd_type OP_ORI     = 6'd22;
   localparam cmd_type OP_ANDI    = 6'd23;
   localparam cmd_type OP_SLLI    = 6'd24;
   localparam cmd_type OP_SRLI    = 6'd25;
   localparam cmd_type OP_SRAI    = 6'd26;
   localparam cmd_type OP_ADD     = 6'd27;
   localparam cmd_type OP_SUB     = 6'd28;
   localparam cmd_type OP_SLL     = 6'd29;
   localparam cmd_type OP_SLT     = 6'd30;
   localparam cmd_type OP_SLTU    = 6'd31;
   localparam cmd_type OP_XOR     = 6'd32;
   localparam cmd_type OP_SRL     = 6'd33;
   localparam cmd_type OP_SRA     = 6'd34;
   localparam cmd_type OP_OR      = 6'd35;
   localparam cmd_type OP_AND     = 6'd36;
   localparam cmd_type OP_FENCE   = 6'd37;
   localparam cmd_type OP_FENCE_I = 6'd38;
   localparam cmd_type OP_ECALL   = 6'd39;
   localparam cmd_type OP_EBREAK  = 6'd40;

   localparam cmd_type MNEM_COUNT = 6'd41;

   localparam lay_type LAY_U = 3'd0;
   localparam lay_type LAY_J = 3'd1;
   localparam lay_type LAY_B = 3'd2;
   localparam lay_type LAY_I = 3'd3;
   localparam lay_type LAY_S = 3'd4;
   localparam lay_type LAY_R = 3'd5;
   localparam lay_type LAY_N = 3'd6;

   function automatic word_type base_word(input cmd_type cmd);
      word_type w;
      case (cmd)
         OP_LUI:     w = 32'h0000_0037;
         OP_AUIPC:   w = 32'h0000_0017;
         OP_JAL:     w = 32'h0000_006f;
         OP_JALR:    w = 32'h0000_0067;
         OP_BEQ:     w = 32'h0000_0063;
         OP_BNE:     w = 32'h0000_1063;
         OP_BLT:     w = 32'h0000_4063;
         OP_BGE:     w = 32'h0000_5063;
         OP_BLTU:    w = 32'h0000_6063;
         OP_BGEU:    w = 32'h0000_7063;
         OP_LB:      w = 32'h0000_0003;
         OP_LH:      w = 32'h0000_1003;
         OP_LW:      w = 32'h0000_2003;
         OP_LBU:     w = 32'h0000_4003;
         OP_LHU:     w = 32'h0000_5003;
         OP_SB:      w = 32'h0000_0023;
         OP_SH:      w = 32'h0000_1023;
         OP_SW:      w = 32'h0000_2023;
         OP_ADDI:    w = 32'h0000_0013;
         OP_SLTI:    w = 32'h0000_2013;
         OP_SLTIU:   w = 32'h0000_3013;
         OP_XORI:    w = 32'h0000_4013;
         OP_ORI:     w = 32'h0000_6013;
         OP_ANDI:    w = 32'h0000_7013;
         OP_SLLI:    w = 32'h0000_1013;
         OP_SRLI:    w = 32'h0000_5013;
         OP_SRAI:    w = 32'h4000_5013;
         OP_ADD:     w = 32'h0000_0033;
         OP_SUB:     w = 32'h4000_0033;
         OP_SLL:     w = 32'h0000_1033;
         OP_SLT:     w = 32'h0000_2033;
         OP_SLTU:    w = 32'h0000_3033;
         OP_XOR:     w = 32'h0000_4033;
         OP_SRL:     w = 32'h0000_5033;
         OP_SRA:     w = 32'h4000_5033;
         OP_OR:      w = 32'h0000_6033;
         OP_AND:     w = 32'h0000_7033;
         OP_FENCE:   w = 32'h0000_000f;
         OP_FENCE_I: w = 32'h0000_100f;
         OP_ECALL:   w = 32'h0000_0073;
         OP_EBREAK:  w = 32'h0010_0073;
         default: w = '0;
      endcase
      return w;
   endfunction

   function automatic lay_type layout_of(input cmd_type cmd);
      lay_type l;
      case (cmd)
         OP_LUI, OP_AUIPC: l = LAY_U;
         OP_JAL: l = LAY_J;
         OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU: l = LAY_B;
         OP_JALR, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_ADDI, OP_SLTI, OP_SLTIU,
         OP_XORI, OP_ORI, OP_ANDI, OP_SLLI, OP_SRLI, OP_SRAI: l = LAY_I;
         OP_SB, OP_SH, OP_SW: l = LAY_S;
         OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA, OP_OR,
         OP_AND: l = LAY_R;
         default: l = LAY_N;
      endcase
      return l;
   endfunction

endpackage

@@ src/rv32i_instruction_encoder.sv @@
// RV32I instruction encoder: input register, packing logic, result register.
// A request taken at an edge passes through the input register and the result register;
// each result is marked for one cycle by rsp_strobe.
// Throughput: one request per cycle; busy is high only during reset.
// Reset clears the request and result strobes; payload registers hold no reset.
// The receiver cannot stall, so no result is ever held back.
module rv32i_instruction_encoder (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  rv32ie_pkg::cmd_type    req_cmd,
   input  rv32ie_pkg::reg_type    req_rd,
   input  rv32ie_pkg::reg_type    req_rs1,
   input  rv32ie_pkg::reg_type    req_rs2,
   input  rv32ie_pkg::word_type   req_imm,
   output logic                   rsp_strobe,
   output rv32ie_pkg::word_type   rsp_word,
   output logic                   rsp_invalid
);

   logic                 req_valid_ff;
   rv32ie_pkg::cmd_type  cmd_ff;
   rv32ie_pkg::reg_type  rd_ff;
   rv32ie_pkg::reg_type  rs1_ff;
   rv32ie_pkg::reg_type  rs2_ff;
   rv32ie_pkg::word_type imm_ff;

   logic                 rsp_valid_ff;
   rv32ie_pkg::word_type word_ff;
   logic                 invalid_ff;

   rv32ie_pkg::word_type word_in;
   logic                 invalid_in;
   rv32ie_pkg::word_type rd_field;
   rv32ie_pkg::word_type rs1_field;
   rv32ie_pkg::word_type rs2_field;
   rv32ie_pkg::lay_type  lay;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start & ~busy;
      end
      if (start & ~busy) begin
         cmd_ff <= req_cmd;
         rd_ff  <= req_rd;
         rs1_ff <= req_rs1;
         rs2_ff <= req_rs2;
         imm_ff <= req_imm;
      end
   end

   assign rd_field  = {20'd0, rd_ff, 7'd0};
   assign rs1_field = {12'd0, rs1_ff, 15'd0};
   assign rs2_field = {7'd0, rs2_ff, 20'd0};
   assign lay       = rv32ie_pkg::layout_of(cmd_ff);

   always_comb begin
      invalid_in = (cmd_ff >= rv32ie_pkg::MNEM_COUNT);
      word_in    = rv32ie_pkg::base_word(cmd_ff);
      case (lay)
         rv32ie_pkg::LAY_U: begin
            word_in = word_in | {imm_ff[19:0], 12'd0} | rd_field;
         end
         rv32ie_pkg::LAY_J: begin
            word_in = word_in | {imm_ff[20], imm_ff[10:1], imm_ff[11], imm_ff[19:12],
                                 12'd0} | rd_field;
         end
         rv32ie_pkg::LAY_B: begin
            word_in = word_in | {imm_ff[12], imm_ff[10:5], 13'd0, imm_ff[4:1],
                                 imm_ff[11], 7'd0} | rs2_field | rs1_field;
         end
         rv32ie_pkg::LAY_I: begin
            word_in = word_in | {imm_ff[11:0], 20'd0} | rs1_field | rd_field;
         end
         rv32ie_pkg::LAY_S: begin
            word_in = word_in | {imm_ff[11:5], 13'd0, imm_ff[4:0], 7'd0}
                      | rs2_field | rs1_field;
         end
         rv32ie_pkg::LAY_R: begin
            word_in = word_in | rs2_field | rs1_field | rd_field;
         end
         default: begin
            word_in = word_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
      if (req_valid_ff) begin
         word_ff    <= word_in;
         invalid_ff <= invalid_in;
      end
   end

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_word    = word_ff;
   assign rsp_invalid = invalid_ff;

endmodule

@@ src/rv32ie_checker.sv @@
// Port-level checker for the RV32I instruction encoder, bound to the encoder module.
`include "rv32i_instruction_encoder_defines.svh"

module rv32ie_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input rv32ie_pkg::cmd_type  req_cmd,
   input logic                 rsp_strobe,
   input rv32ie_pkg::word_type rsp_word,
   input logic                 rsp_invalid
);

   logic req_fire;
   logic cmd_bad;

   assign req_fire = start && !busy;
   assign cmd_bad  = (req_cmd >= rv32ie_pkg::MNEM_COUNT);

   `RIE_ASSERT(a_req_gives_rsp, req_fire |-> ##2 rsp_strobe, "request lost")
   `RIE_ASSERT(a_no_req_no_rsp, !req_fire |-> ##2 !rsp_strobe, "result invented")
   `RIE_ASSERT(a_invalid_zero, (rsp_strobe && rsp_invalid) |-> (rsp_word == '0), "bad word")
   `RIE_ASSERT(a_invalid_code, rsp_strobe |-> (rsp_invalid == $past(cmd_bad, 2)), "bad flag")
   `RIE_ASSERT_RST(a_reset_quiet, reset |=> !rsp_strobe, "strobe after reset")

endmodule

bind rv32i_instruction_encoder rv32ie_checker u_checker (.*);

@@ bench/tb.sv @@
// Self-checking bench for the RV32I instruction encoder: directed and random requests.
`timescale 1ns / 100ps

module tb;

   typedef enum logic [2:0] {FMT_U, FMT_J, FMT_B, FMT_I, FMT_S, FMT_R, FMT_BARE} fmt_type;

   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6f;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_FENCE  = 7'h0f;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;
   localparam logic [6:0] F7_ALT     = 7'h20;
   localparam rv32ie_pkg::word_type EBREAK_BIT = 32'h0010_0000;
   localparam rv32ie_pkg::cmd_type  LAST_CMD   = 6'h3f;
   localparam int unsigned RANDOM_REQUESTS = 1850;

   typedef struct {
      rv32ie_pkg::cmd_type  cmd;
      rv32ie_pkg::reg_type  rd;
      rv32ie_pkg::reg_type  rs1;
      rv32ie_pkg::reg_type  rs2;
      rv32ie_pkg::word_type imm;
      int unsigned          gap;
      bit                   drain;
   } enc_request_type;

   typedef struct {
      rv32ie_pkg::cmd_type  cmd;
      rv32ie_pkg::word_type word;
      logic                 invalid;
   } enc_word_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   rv32ie_pkg::cmd_type  req_cmd = '0;
   rv32ie_pkg::reg_type  req_rd = '0;
   rv32ie_pkg::reg_type  req_rs1 = '0;
   rv32ie_pkg::reg_type  req_rs2 = '0;
   rv32ie_pkg::word_type req_imm = '0;
   logic                 rsp_strobe;
   rv32ie_pkg::word_type rsp_word;
   logic                 rsp_invalid;

   enc_request_type request_q[$];
   enc_word_type    expected_q[$];
   enc_request_type next_req;
   enc_word_type    got_word;
   int unsigned     gap_left = 0;
   int unsigned     words_in_flight = 0;
   int unsigned     mismatches = 0;

   rv32i_instruction_encoder uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_rd(req_rd),
      .req_rs1(req_rs1),
      .req_rs2(req_rs2),
      .req_imm(req_imm),
      .rsp_strobe(rsp_strobe),
      .rsp_word(rsp_word),
      .rsp_invalid(rsp_invalid)
   );

   function automatic enc_word_type encode_request(input rv32ie_pkg::cmd_type cmd,
                                                   input rv32ie_pkg::reg_type rd,
                                                   input rv32ie_pkg::reg_type rs1,
                                                   input rv32ie_pkg::reg_type rs2,
                                                   input rv32ie_pkg::word_type imm);
      logic [6:0]           opc;
      logic [6:0]           f7;
      logic [2:0]           f3;
      rv32ie_pkg::word_type w;
      rv32ie_pkg::word_type extra;
      fmt_type              fmt;
      enc_word_type         res;
      opc = '0;
      f7 = '0;
      f3 = '0;
      extra = '0;
      fmt = FMT_BARE;
      res.cmd = cmd;
      res.invalid = 1'b0;
      case (cmd)
         rv32ie_pkg::OP_LUI:   begin opc = OPC_LUI; fmt = FMT_U; end
         rv32ie_pkg::OP_AUIPC: begin opc = OPC_AUIPC; fmt = FMT_U; end
         rv32ie_pkg::OP_JAL:   begin opc = OPC_JAL; fmt = FMT_J; end
         rv32ie_pkg::OP_JALR:  begin opc = OPC_JALR; fmt = FMT_I; end
         rv32ie_pkg::OP_BEQ:   begin opc = OPC_BRANCH; fmt = FMT_B; f3 = 3'd0; end
         rv32ie_pkg::OP_BNE:   begin opc = OPC_BRANCH; fmt = FMT_B; f3 = 3'd1; end
         rv32ie_pkg::OP_BLT:   begin opc = OPC_BRANCH; fmt = FMT_B; f3 = 3'd4; end
         rv32ie_pkg::OP_BGE:   begin opc = OPC_BRANCH; fmt = FMT_B; f3 = 3'd5; end
         rv32ie_pkg::OP_BLTU:  begin opc = OPC_BRANCH; fmt = FMT_B; f3 = 3'd6; end
         rv32ie_pkg::OP_BGEU:  begin opc = OPC_BRANCH; fmt = FMT_B; f3 = 3'd7; end
         rv32ie_pkg::OP_LB:    begin opc = OPC_LOAD; fmt = FMT_I; f3 = 3'd0; end
         rv32ie_pkg::OP_LH:    begin opc = OPC_LOAD; fmt = FMT_I; f3 = 3'd1; end
         rv32ie_pkg::OP_LW:    begin opc = OPC_LOAD; fmt = FMT_I; f3 = 3'd2; end
         rv32ie_pkg::OP_LBU:   begin opc = OPC_LOAD; fmt = FMT_I; f3 = 3'd4; end
         rv32ie_pkg::OP_LHU:   begin opc = OPC_LOAD; fmt = FMT_I; f3 = 3'd5; end
         rv32ie_pkg::OP_SB:    begin opc = OPC_STORE; fmt = FMT_S; f3 = 3'd0; end
         rv32ie_pkg::OP_SH:    begin opc = OPC_STORE; fmt = FMT_S; f3 = 3'd1; end
         rv32ie_pkg::OP_SW:    begin opc = OPC_STORE; fmt = FMT_S; f3 = 3'd2; end
         rv32ie_pkg::OP_ADDI:  begin opc = OPC_OPIMM; fmt = FMT_I; f3 = 3'd0; end
         rv32ie_pkg::OP_SLTI:  begin opc = OPC_OPIMM; fmt = FMT_I; f3 = 3'd2; end
         rv32ie_pkg::OP_SLTIU: begin opc = OPC_OPIMM; fmt = FMT_I; f3 = 3'd3; end
         rv32ie_pkg::OP_XORI:  begin opc = OPC_OPIMM; fmt = FMT_I; f3 = 3'd4; end
         rv32ie_pkg::OP_ORI:   begin opc = OPC_OPIMM; fmt = FMT_I; f3 = 3'd6; end
         rv32ie_pkg::OP_ANDI:  begin opc = OPC_OPIMM; fmt = FMT_I; f3 = 3'd7; end
         rv32ie_pkg::OP_SLLI:  begin opc = OPC_OPIMM; fmt = FMT_I; f3 = 3'd1; end
         rv32ie_pkg::OP_SRLI:  begin opc = OPC_OPIMM; fmt = FMT_I; f3 = 3'd5; end
         rv32ie_pkg::OP_SRAI:  begin
            opc = OPC_OPIMM; fmt = FMT_I; f3 = 3'd5; f7 = F7_ALT;
         end
         rv32ie_pkg::OP_ADD:   begin opc = OPC_OP; fmt = FMT_R; f3 = 3'd0; end
         rv32ie_pkg::OP_SUB:   begin opc = OPC_OP; fmt = FMT_R; f3 = 3'd0; f7 = F7_ALT; end
         rv32ie_pkg::OP_SLL:   begin opc = OPC_OP; fmt = FMT_R; f3 = 3'd1; end
         rv32ie_pkg::OP_SLT:   begin opc = OPC_OP; fmt = FMT_R; f3 = 3'd2; end
         rv32ie_pkg::OP_SLTU:  begin opc = OPC_OP; fmt = FMT_R; f3 = 3'd3; end
         rv32ie_pkg::OP_XOR:   begin opc = OPC_OP; fmt = FMT_R; f3 = 3'd4; end
         rv32ie_pkg::OP_SRL:   begin opc = OPC_OP; fmt = FMT_R; f3 = 3'd5; end
         rv32ie_pkg::OP_SRA:   begin opc = OPC_OP; fmt = FMT_R; f3 = 3'd5; f7 = F7_ALT; end
         rv32ie_pkg::OP_OR:    begin opc = OPC_OP; fmt = FMT_R; f3 = 3'd6; end
         rv32ie_pkg::OP_AND:   begin opc = OPC_OP; fmt = FMT_R; f3 = 3'd7; end
         rv32ie_pkg::OP_FENCE:   begin opc = OPC_FENCE; f3 = 3'd0; end
         rv32ie_pkg::OP_FENCE_I: begin opc = OPC_FENCE; f3 = 3'd1; end
         rv32ie_pkg::OP_ECALL:   begin opc = OPC_SYSTEM; end
         rv32ie_pkg::OP_EBREAK:  begin opc = OPC_SYSTEM; extra = EBREAK_BIT; end
         default: res.invalid = 1'b1;
      endcase
      w = {f7, 5'b0, 5'b0, f3, 5'b0, opc} | extra;
      case (fmt)
         FMT_U: w |= {imm[19:0], rd, 7'b0};
         FMT_J: w |= {imm[20], imm[10:1], imm[11], imm[19:12], rd, 7'b0};
         FMT_B: w |= {imm[12], imm[10:5], rs2, rs1, 3'b0, imm[4:1], imm[11], 7'b0};
         FMT_I: w |= {imm[11:0], rs1, 3'b0, rd, 7'b0};
         FMT_S: w |= {imm[11:5], rs2, rs1, 3'b0, imm[4:0], 7'b0};
         FMT_R: w |= {7'b0, rs2, rs1, 3'b0, rd, 7'b0};
         default: ;
      endcase
      res.word = res.invalid ? '0 : w;
      return res;
   endfunction

   function automatic void queue_request(input rv32ie_pkg::cmd_type cmd,
                                         input rv32ie_pkg::reg_type rd,
                                         input rv32ie_pkg::reg_type rs1,
                                         input rv32ie_pkg::reg_type rs2,
                                         input rv32ie_pkg::word_type imm,
                                         input int unsigned gap,
                                         input bit drain);
      enc_request_type r;
      r.cmd = cmd;
      r.rd = rd;
      r.rs1 = rs1;
      r.rs2 = rs2;
      r.imm = imm;
      r.gap = gap;
      r.drain = drain;
      request_q.push_back(r);
   endfunction

   function automatic rv32ie_pkg::word_type random_imm();
      rv32ie_pkg::word_type v;
      v = $urandom;
      case ($urandom_range(0, 3))
         0: ;
         1: v = {{20{v[11]}}, v[11:0]};
         2: v = {{11{v[20]}}, v[20:1], 1'b0};
         default:
            case ($urandom_range(0, 3))
               0: v = '0;
               1: v = '1;
               2: v = 32'h8000_0000;
               default: v = 32'h7fff_ffff;
            endcase
      endcase
      return v;
   endfunction

   function automatic rv32ie_pkg::reg_type random_reg();
      return rv32ie_pkg::reg_type'($urandom_range(0, 31));
   endfunction

   task automatic build_requests();
      rv32ie_pkg::cmd_type cmd;
      int unsigned         gap;
      bit                  drain;
      queue_request(rv32ie_pkg::OP_LUI, 5'd31, 5'd0, 5'd0, 32'hffff_ffff, 0, 1'b0);
      queue_request(rv32ie_pkg::OP_AUIPC, 5'd0, 5'd31, 5'd31, 32'h0000_0000, 0, 1'b0);
      queue_request(rv32ie_pkg::OP_JAL, 5'd31, 5'd0, 5'd0, 32'hffff_ffff, 2, 1'b0);
      queue_request(rv32ie_pkg::OP_JAL, 5'd1, 5'd31, 5'd31, 32'h0015_5556, 0, 1'b0);
      queue_request(rv32ie_pkg::OP_JALR, 5'd31, 5'd31, 5'd31, 32'hffff_f800, 0, 1'b0);
      queue_request(rv32ie_pkg::OP_BEQ, 5'd31, 5'd31, 5'd31, 32'hffff_ffff, 0, 1'b0);
      queue_request(rv32ie_pkg::OP_BGEU, 5'd0, 5'd0, 5'd0, 32'h0000_1aaa, 0, 1'b1);
      queue_request(rv32ie_pkg::OP_LB, 5'd0, 5'd0, 5'd0, 32'h0000_07ff, 3, 1'b0);
      queue_request(rv32ie_pkg::OP_LHU, 5'd31, 5'd31, 5'd31, 32'hffff_f800, 0, 1'b0);
      queue_request(rv32ie_pkg::OP_SB, 5'd31, 5'd31, 5'd0, 32'hffff_ffff, 0, 1'b0);
      queue_request(rv32ie_pkg::OP_SH, 5'd0, 5'd0, 5'd31, 32'h0000_0fe0, 0, 1'b0);
      queue_request(rv32ie_pkg::OP_SW, 5'd31, 5'd31, 5'd31, 32'h0000_001f, 0, 1'b0);
      queue_request(rv32ie_pkg::OP_ADDI, 5'd31, 5'd31, 5'd31, 32'h8000_0000, 0, 1'b0);
      queue_request(rv32ie_pkg::OP_ANDI, 5'd1, 5'd2, 5'd3, 32'h7fff_ffff, 1, 1'b0);
      queue_request(rv32ie_pkg::OP_SLLI, 5'd31, 5'd0, 5'd0, 32'h0000_001f, 0, 1'b0);
      queue_request(rv32ie_pkg::OP_SRLI, 5'd0, 5'd31, 5'd0, 32'h0000_0fff, 0, 1'b0);
      queue_request(rv32ie_pkg::OP_SRAI, 5'd31, 5'd31, 5'd0, 32'h0000_0fe5, 0, 1'b0);
      queue_request(rv32ie_pkg::OP_ADD, 5'd31, 5'd31, 5'd31, 32'hffff_ffff, 0, 1'b0);
      queue_request(rv32ie_pkg::OP_SUB, 5'd0, 5'd0, 5'd0, 32'h0000_0000, 0, 1'b0);
      queue_request(rv32ie_pkg::OP_SRA, 5'd17, 5'd10, 5'd5, 32'h1234_5678, 0, 1'b0);
      queue_request(rv32ie_pkg::OP_AND, 5'd31, 5'd0, 5'd31, 32'h0000_0000, 0, 1'b0);
      queue_request(rv32ie_pkg::OP_FENCE, 5'd31, 5'd31, 5'd31, 32'hffff_ffff, 0, 1'b0);
      queue_request(rv32ie_pkg::OP_FENCE_I, 5'd31, 5'd31, 5'd31, 32'hffff_ffff, 0, 1'b0);
      queue_request(rv32ie_pkg::OP_ECALL, 5'd31, 5'd31, 5'd31, 32'hffff_ffff, 0, 1'b0);
      queue_request(rv32ie_pkg::OP_EBREAK, 5'd31, 5'd31, 5'd31, 32'hffff_ffff, 0, 1'b0);
      queue_request(rv32ie_pkg::MNEM_COUNT, 5'd31, 5'd31, 5'd31, 32'hffff_ffff, 0, 1'b0);
      queue_request(LAST_CMD, 5'd31, 5'd31, 5'd31, 32'hffff_ffff, 0, 1'b1);
      for (int unsigned i = 0; i < RANDOM_REQUESTS; i++) begin
         if ($urandom_range(0, 99) < 8)
            cmd = rv32ie_pkg::cmd_type'($urandom_range(rv32ie_pkg::MNEM_COUNT, LAST_CMD));
         else
            cmd = rv32ie_pkg::cmd_type'($urandom_range(rv32ie_pkg::OP_LUI,
                                                       rv32ie_pkg::OP_EBREAK));
         if (i >= 1650 || (i >= 600 && i < 800) || $urandom_range(0, 2) != 0)
            gap = 0;
         else
            gap = $urandom_range(1, 7);
         drain = (i < 1650) && (i == 50 || $urandom_range(0, 199) == 0);
         queue_request(cmd, random_reg(), random_reg(), random_reg(), random_imm(),
                       gap, drain);
      end
   endtask

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s", $realtime, what);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400_000;
      $display("FAIL");
      $finish;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (!start || !busy) begin
         if (gap_left != 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (request_q.size() != 0 &&
                      !(request_q[0].drain && (start || words_in_flight != 0))) begin
            next_req = request_q.pop_front();
            req_cmd <= next_req.cmd;
            req_rd <= next_req.rd;
            req_rs1 <= next_req.rs1;
            req_rs2 <= next_req.rs2;
            req_imm <= next_req.imm;
            gap_left <= next_req.gap;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check results first, then record the request taken at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (expected_q.size() == 0) begin
               note_mismatch($sformatf("unexpected word %h invalid %b", rsp_word, rsp_invalid));
            end else begin
               got_word = expected_q.pop_front();
               if (rsp_word !== got_word.word || rsp_invalid !== got_word.invalid)
                  note_mismatch($sformatf("cmd %0d: expected word %h invalid %b, got %h %b",
                                          got_word.cmd, got_word.word, got_word.invalid,
                                          rsp_word, rsp_invalid));
            end
         end
         if (start && !busy)
            expected_q.push_back(encode_request(req_cmd, req_rd, req_rs1, req_rs2, req_imm));
         words_in_flight <= expected_q.size();
      end
   end

   initial begin
      build_requests();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (request_q.size() != 0 || start || words_in_flight != 0)
         @(negedge clock);
      repeat (10) @(posedge clock);
      @(negedge clock);
      if (expected_q.size() != 0)
         note_mismatch($sformatf("%0d words never arrived", expected_q.size()));
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
